[rtl/core/hro_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hro_pkg
// Shared widths and types for the right-of-half-edge test pipeline.
// ----------------------------------------------------------------------------
package hro_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_BITS = 32;

  localparam int ITEM_BITS = 8 * COORD_BITS + 1;
  localparam int IN_BITS   = ((ITEM_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 8;

  // operand width of the split multipliers and their product width
  localparam int MW = 2 * COORD_BITS + 4;
  localparam int MH = MW / 2;
  localparam int PW = 2 * MW;

  typedef struct packed {
    logic                         half_side;
    logic signed [COORD_BITS-1:0] line_c;
    logic signed [COORD_BITS-1:0] line_b;
    logic signed [COORD_BITS-1:0] line_a;
    logic signed [COORD_BITS-1:0] bottom_site_x;
    logic signed [COORD_BITS-1:0] top_site_y;
    logic signed [COORD_BITS-1:0] top_site_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_x;
  } hro_item_t;

  typedef struct packed {
    logic side;
    logic rs;
    logic unit;
    logic b_neg;
    logic f1;
    logic f2;
  } hro_ctl_t;

endpackage

[rtl/core/hro_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hro_front
// First two stages: differences and narrow products, then the fast tests
// and the operands of the wide products.
// ----------------------------------------------------------------------------
module hro_front (
  input  logic                            clk,
  input  logic                            en1,
  input  logic                            en2,
  input  hro_pkg::hro_item_t              item,
  output hro_pkg::hro_ctl_t               ctl,
  output logic signed [hro_pkg::MW-1:0]   lin,
  output logic signed [hro_pkg::MW-1:0]   m0_a,
  output logic signed [hro_pkg::MW-1:0]   m0_b,
  output logic signed [hro_pkg::MW-1:0]   m1_a,
  output logic signed [hro_pkg::MW-1:0]   m1_b,
  output logic signed [hro_pkg::MW-1:0]   m2_a,
  output logic signed [hro_pkg::MW-1:0]   m3_a,
  output logic signed [hro_pkg::MW-1:0]   m4_a
);

  localparam int W  = hro_pkg::COORD_BITS;
  localparam int F  = hro_pkg::FRAC_BITS;
  localparam int MW = hro_pkg::MW;

  hro_pkg::hro_ctl_t     s1_ctl;
  logic signed [W-1:0]   s1_px, s1_py, s1_ty, s1_c, s1_b;
  logic signed [W:0]     s1_dxp, s1_dyp;
  logic signed [2*W-1:0] s1_apx, s1_pyb, s1_b2;
  logic signed [2*W:0]   s1_bdxp;
  logic signed [2*W+1:0] s1_dxp2, s1_dyp2, s1_sy, s1_xy;

  logic signed [W:0]     dxp, dyp, dxs;
  logic signed [MW-1:0]  dyp_s, bdxp_e, px_s, pyb_e, c_s, py_s, ty_s, yl;
  logic                  f1, f2;

  always_comb begin
    dxp = (W+1)'(item.point_x) - (W+1)'(item.top_site_x);
    dyp = (W+1)'(item.point_y) - (W+1)'(item.top_site_y);
    dxs = (W+1)'(item.top_site_x) - (W+1)'(item.bottom_site_x);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ctl.side  <= item.half_side;
      s1_ctl.rs    <= item.point_x > item.top_site_x;
      s1_ctl.unit  <= item.line_a == W'(1 << F);
      s1_ctl.b_neg <= item.line_b[W-1];
      s1_ctl.f1    <= 1'b0;
      s1_ctl.f2    <= 1'b0;
      s1_px   <= item.point_x;
      s1_py   <= item.point_y;
      s1_ty   <= item.top_site_y;
      s1_c    <= item.line_c;
      s1_b    <= item.line_b;
      s1_dxp  <= dxp;
      s1_dyp  <= dyp;
      s1_apx  <= item.line_a * item.point_x;
      s1_pyb  <= item.point_y * item.line_b;
      s1_b2   <= item.line_b * item.line_b;
      s1_bdxp <= item.line_b * dxp;
      s1_dxp2 <= dxp * dxp;
      s1_dyp2 <= dyp * dyp;
      s1_sy   <= dxs * dyp;
      s1_xy   <= dxp * dyp;
    end
  end

  always_comb begin
    dyp_s  = MW'(s1_dyp) <<< F;
    bdxp_e = MW'(s1_bdxp);
    px_s   = MW'(s1_px) <<< F;
    pyb_e  = MW'(s1_pyb);
    c_s    = MW'(s1_c) <<< F;
    py_s   = MW'(s1_py) <<< F;
    ty_s   = MW'(s1_ty) <<< F;
    yl     = c_s - MW'(s1_apx);
    f1     = dyp_s >= bdxp_e;
    f2     = c_s < (px_s + pyb_e);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ctl       <= '{side: s1_ctl.side, rs: s1_ctl.rs, unit: s1_ctl.unit,
                     b_neg: s1_ctl.b_neg, f1: f1, f2: f2};
      lin       <= MW'(s1_sy) + (MW'(s1_xy) <<< 1);
      m0_a      <= MW'(s1_b);
      m0_b      <= MW'(s1_dxp2) - MW'(s1_dyp2);
      m1_a      <= MW'(s1_sy);
      m1_b      <= MW'(s1_b2);
      m2_a      <= MW'(s1_dxp) <<< F;
      m3_a      <= yl - ty_s;
      m4_a      <= py_s - yl;
    end
  end

endmodule

[rtl/core/hro_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hro_mul
// Two-stage wide signed multiplier: four half-width partial products,
// then their aligned sum.
// ----------------------------------------------------------------------------
module hro_mul (
  input  logic                           clk,
  input  logic                           en1,
  input  logic                           en2,
  input  logic signed [hro_pkg::MW-1:0]  a,
  input  logic signed [hro_pkg::MW-1:0]  b,
  output logic signed [hro_pkg::PW-1:0]  p
);

  localparam int MW = hro_pkg::MW;
  localparam int MH = hro_pkg::MH;
  localparam int PW = hro_pkg::PW;
  localparam int HW = MW - MH;

  logic signed [MH:0]        a_lo, b_lo;
  logic signed [HW-1:0]      a_hi, b_hi;
  logic signed [2*MH+1:0]    pp_ll;
  logic signed [MH+HW:0]     pp_lh, pp_hl;
  logic signed [2*HW-1:0]    pp_hh;

  always_comb begin
    a_lo = $signed({1'b0, a[MH-1:0]});
    b_lo = $signed({1'b0, b[MH-1:0]});
    a_hi = a[MW-1:MH];
    b_hi = b[MW-1:MH];
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pp_ll <= a_lo * b_lo;
      pp_lh <= a_lo * b_hi;
      pp_hl <= a_hi * b_lo;
      pp_hh <= a_hi * b_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      p <= (PW'(pp_hh) <<< (2 * MH)) + ((PW'(pp_lh) + PW'(pp_hl)) <<< MH) + PW'(pp_ll);
    end
  end

endmodule

[rtl/core/halfedge_right_of_test_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// halfedge_right_of_test_unit
// Fortune beach-line predicate: is the query point right of the half-edge.
// ----------------------------------------------------------------------------
// One word per cycle enters a five-stage pipeline while it is not stalled;
// stage one forms the 33-bit coordinate differences and the narrow products
// of up to 66 bits, stage two the fast tests and the wide operands, stages
// three and four the split wide multipliers, stage five the final compare into
// the output register. Each stage holds only while it is full and the stage
// after it holds, so bubbles close up under back pressure.
module halfedge_right_of_test_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // point_x, point_y, top_site_x, top_site_y, bottom_site_x,
  // line_a, line_b, line_c, half_side, zero fill
  input  logic [hro_pkg::IN_BITS-1:0]  s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // is_right, zero fill
  output logic [hro_pkg::OUT_BITS-1:0] m_tdata
);

  localparam int F  = hro_pkg::FRAC_BITS;
  localparam int MW = hro_pkg::MW;
  localparam int PW = hro_pkg::PW;
  localparam int CW = PW + F + 2;
  localparam int SW = PW + 1;

  hro_pkg::hro_item_t item;
  hro_pkg::hro_ctl_t  ctl2, ctl3, ctl4;
  logic signed [MW-1:0] lin2, lin3, lin4;
  logic signed [MW-1:0] m0_a, m0_b, m1_a, m1_b, m2_a, m3_a, m4_a;
  logic signed [PW-1:0] m0_p, m1_p, m2_p, m3_p, m4_p;
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;
  logic signed [CW-1:0] lhs, rhs;
  logic signed [SW-1:0] dsum, dref;
  logic par_lt, dist_lt, sel1, fast, above, is_right;

  assign item = hro_pkg::hro_item_t'(s_tdata[hro_pkg::ITEM_BITS-1:0]);

  assign en5 = !m_tvalid || m_tready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) m_tvalid <= v4;
    end
  end

  hro_front u_front (
    .clk  (clk),
    .en1  (en1),
    .en2  (en2),
    .item (item),
    .ctl  (ctl2),
    .lin  (lin2),
    .m0_a (m0_a),
    .m0_b (m0_b),
    .m1_a (m1_a),
    .m1_b (m1_b),
    .m2_a (m2_a),
    .m3_a (m3_a),
    .m4_a (m4_a)
  );

  hro_mul u_mul0 (.clk(clk), .en1(en3), .en2(en4), .a(m0_a), .b(m0_b), .p(m0_p));
  hro_mul u_mul1 (.clk(clk), .en1(en3), .en2(en4), .a(m1_a), .b(m1_b), .p(m1_p));
  hro_mul u_mul2 (.clk(clk), .en1(en3), .en2(en4), .a(m2_a), .b(m2_a), .p(m2_p));
  hro_mul u_mul3 (.clk(clk), .en1(en3), .en2(en4), .a(m3_a), .b(m3_a), .p(m3_p));
  hro_mul u_mul4 (.clk(clk), .en1(en3), .en2(en4), .a(m4_a), .b(m4_a), .p(m4_p));

  always_ff @(posedge clk) begin
    if (en3) begin
      ctl3 <= ctl2;
      lin3 <= lin2;
    end
    if (en4) begin
      ctl4 <= ctl3;
      lin4 <= lin3;
    end
  end

  always_comb begin
    lhs     = CW'(m0_p) <<< F;
    rhs     = (CW'(lin4) <<< (2 * F)) + CW'(m1_p);
    par_lt  = lhs < rhs;
    dsum    = SW'(m2_p) + SW'(m3_p);
    dref    = SW'(m4_p);
    dist_lt = dsum < dref;
    sel1    = ctl4.rs ^ ctl4.b_neg;
    if (sel1) begin
      above = ctl4.f1;
      fast  = ctl4.f1;
    end else begin
      above = ctl4.f2 ^ ctl4.b_neg;
      fast  = !above;
    end
    if (!fast) above = par_lt ^ ctl4.b_neg;
    if (!ctl4.unit) above = dist_lt;
    if (ctl4.rs && !ctl4.side) begin
      is_right = 1'b1;
    end else if (!ctl4.rs && ctl4.side) begin
      is_right = 1'b0;
    end else begin
      is_right = ctl4.side ? !above : above;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      m_tdata <= {{(hro_pkg::OUT_BITS-1){1'b0}}, is_right};
    end
  end

endmodule

[rtl/core/hro_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hro_checker
// Port-level checks for the right-of-half-edge test unit.
// ----------------------------------------------------------------------------
module hro_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [hro_pkg::IN_BITS-1:0]  s_tdata,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [hro_pkg::OUT_BITS-1:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word dropped or changed under stall");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_take_ready: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[hro_pkg::OUT_BITS-1:1] == '0)
    else $error("nonzero fill bits in output word");

endmodule

bind halfedge_right_of_test_unit hro_checker u_hro_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
